### hw/rtl/distance_constraint_projection_defines.svh
// Assertion macros for the distance constraint projection checker
`ifndef DISTANCE_CONSTRAINT_PROJECTION_DEFINES_SVH
`define DISTANCE_CONSTRAINT_PROJECTION_DEFINES_SVH

// check while out of reset
`define DCP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check across reset as well
`define DCP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/dcp_pkg.sv
// Shared types, widths and codes for the distance constraint projection pipeline
package dcp_pkg;

  localparam int IN_W      = 256;
  localparam int OUT_W     = 160;
  localparam int DIST_W    = 34;
  localparam int SQ_W      = 66;
  localparam int RAD_W     = 68;
  localparam int SREM_W    = 35;
  localparam int PROD_W    = 67;
  localparam int NUM_W     = 99;
  localparam int Q_W       = 34;
  localparam int SQ_STAGES = RAD_W / 2;
  localparam int LANES     = 4;

  localparam logic [1:0] ST_CORRECTED  = 2'd0;
  localparam logic [1:0] ST_MASS_ZERO  = 2'd1;
  localparam logic [1:0] ST_COINCIDENT = 2'd2;

  typedef struct packed {
    logic [15:0]        i1;
    logic [15:0]        i2;
    logic [30:0]        rest;
    logic signed [31:0] p1x;
    logic signed [31:0] p1y;
    logic signed [31:0] p2x;
    logic signed [31:0] p2y;
    logic [31:0]        w1;
    logic [31:0]        w2;
    logic [32:0]        wsum;
    logic               nx;
    logic               ny;
    logic [32:0]        ax;
    logic [32:0]        ay;
    logic               massz;
  } side_t;

  typedef struct packed {
    side_t               sd;
    logic [RAD_W-1:0]    v;
    logic [DIST_W-1:0]   root;
    logic [SREM_W-1:0]   rem;
  } sq_t;

  typedef struct packed {
    side_t               sd;
    logic [DIST_W-1:0]   dlen;
    logic [DIST_W-1:0]   mabs;
    logic                mneg;
    logic [1:0]          st;
  } mid_t;

  typedef struct packed {
    logic [15:0]                     i1;
    logic [15:0]                     i2;
    logic signed [31:0]              p1x;
    logic signed [31:0]              p1y;
    logic signed [31:0]              p2x;
    logic signed [31:0]              p2y;
    logic [LANES-1:0]                neg;
    logic [1:0]                      st;
    logic [PROD_W-1:0]               den;
    logic [LANES-1:0][NUM_W-1:0]     num;
    logic [LANES-1:0][PROD_W-1:0]    rem;
    logic [LANES-1:0][Q_W-1:0]       q;
  } dv_t;

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -36'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

### hw/rtl/distance_constraint_projection.sv
// Pipelined position based dynamics distance constraint projection, Q16.16
// One constraint enters per cycle while the output is not stalled; its corrected
// positions leave through 76 register stages, most of them in the 34-stage square
// root (one result bit per stage) and the 34-stage restoring divider (one quotient
// bit per stage, four lanes sharing a divisor).
// The whole pipeline holds when the output transfer stalls, so s_tready follows m_tready
// whenever a result is waiting. Results are saturated to signed 32 bits; m_tuser reports
// corrected, both-masses-zero skip or coincident-points skip.
module distance_constraint_projection (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // first_index, second_index, rest_length, first_x, first_y, second_x, second_y,
  // first_inv_mass, second_inv_mass, zero pad
  input  logic [dcp_pkg::IN_W-1:0] s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // out_first_index, out_second_index, new_first_x, new_first_y, new_second_x,
  // new_second_y
  output logic [dcp_pkg::OUT_W-1:0] m_tdata,
  // status
  output logic [1:0]               m_tuser
);
  import dcp_pkg::*;

  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // input decode
  side_t in_sd;
  logic signed [32:0] dx, dy;
  always_comb begin
    in_sd.i1    = s_tdata[15:0];
    in_sd.i2    = s_tdata[31:16];
    in_sd.rest  = s_tdata[62:32];
    in_sd.p1x   = s_tdata[94:63];
    in_sd.p1y   = s_tdata[126:95];
    in_sd.p2x   = s_tdata[158:127];
    in_sd.p2y   = s_tdata[190:159];
    in_sd.w1    = s_tdata[222:191];
    in_sd.w2    = s_tdata[254:223];
    in_sd.wsum  = {1'b0, in_sd.w1} + {1'b0, in_sd.w2};
    in_sd.massz = (in_sd.w1 == '0) && (in_sd.w2 == '0);
    dx = {in_sd.p1x[31], in_sd.p1x} - {in_sd.p2x[31], in_sd.p2x};
    dy = {in_sd.p1y[31], in_sd.p1y} - {in_sd.p2y[31], in_sd.p2y};
    in_sd.nx = dx[32];
    in_sd.ny = dy[32];
    in_sd.ax = dx[32] ? 33'(-dx) : 33'(dx);
    in_sd.ay = dy[32] ? 33'(-dy) : 33'(dy);
  end

  // stage 1: register operands
  side_t s1;
  logic  v1;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      s1 <= in_sd;
    end
  end

  // stage 2: squares
  side_t s2;
  logic  v2;
  logic [SQ_W-1:0] sqa, sqb;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ce) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      s2  <= s1;
      sqa <= SQ_W'(s1.ax) * SQ_W'(s1.ax);
      sqb <= SQ_W'(s1.ay) * SQ_W'(s1.ay);
    end
  end

  // square root, one bit per stage
  sq_t  sq  [SQ_STAGES+1];
  logic sqv [SQ_STAGES+1];
  always_ff @(posedge clk) begin
    if (rst) begin
      sqv[0] <= 1'b0;
    end else if (ce) begin
      sqv[0] <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      sq[0].sd   <= s2;
      sq[0].v    <= RAD_W'(sqa) + RAD_W'(sqb);
      sq[0].root <= '0;
      sq[0].rem  <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    logic [SREM_W+1:0] r2, trial;
    always_comb begin
      r2    = {sq[k].rem, sq[k].v[RAD_W-1-2*k -: 2]};
      trial = {1'b0, sq[k].root, 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        sqv[k+1] <= 1'b0;
      end else if (ce) begin
        sqv[k+1] <= sqv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        sq[k+1].sd <= sq[k].sd;
        sq[k+1].v  <= sq[k].v;
        if (r2 >= trial) begin
          sq[k+1].rem  <= SREM_W'(r2 - trial);
          sq[k+1].root <= {sq[k].root[DIST_W-2:0], 1'b1};
        end else begin
          sq[k+1].rem  <= SREM_W'(r2);
          sq[k+1].root <= {sq[k].root[DIST_W-2:0], 1'b0};
        end
      end
    end
  end

  // stage 4: length error and skip status
  mid_t m4;
  logic v4;
  logic signed [DIST_W:0] mdiff;
  assign mdiff = {1'b0, sq[SQ_STAGES].root} - (DIST_W+1)'(sq[SQ_STAGES].sd.rest);
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ce) begin
      v4 <= sqv[SQ_STAGES];
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      m4.sd   <= sq[SQ_STAGES].sd;
      m4.dlen <= sq[SQ_STAGES].root;
      m4.mneg <= mdiff[DIST_W];
      m4.mabs <= mdiff[DIST_W] ? DIST_W'(-mdiff) : DIST_W'(mdiff);
      if (sq[SQ_STAGES].sd.massz) begin
        m4.st <= ST_MASS_ZERO;
      end else if (sq[SQ_STAGES].root == '0) begin
        m4.st <= ST_COINCIDENT;
      end else begin
        m4.st <= ST_CORRECTED;
      end
    end
  end

  // stage 5: error times components, divisor
  mid_t m5;
  logic v5;
  logic [PROD_W-1:0] px, py, den5;
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (ce) begin
      v5 <= v4;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      m5   <= m4;
      px   <= PROD_W'(m4.mabs) * PROD_W'(m4.sd.ax);
      py   <= PROD_W'(m4.mabs) * PROD_W'(m4.sd.ay);
      den5 <= PROD_W'(m4.sd.wsum) * PROD_W'(m4.dlen);
    end
  end

  // stage 6: partial products with the weights, lanes x1 y1 x2 y2
  mid_t m6;
  logic v6;
  logic [PROD_W-1:0] den6;
  logic [LANES-1:0][65:0] plo;
  logic [LANES-1:0][64:0] phi;
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (ce) begin
      v6 <= v5;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      m6     <= m5;
      den6   <= den5;
      plo[0] <= 66'(px[33:0]) * 66'(m5.sd.w1);
      phi[0] <= 65'(px[66:34]) * 65'(m5.sd.w1);
      plo[1] <= 66'(py[33:0]) * 66'(m5.sd.w1);
      phi[1] <= 65'(py[66:34]) * 65'(m5.sd.w1);
      plo[2] <= 66'(px[33:0]) * 66'(m5.sd.w2);
      phi[2] <= 65'(px[66:34]) * 65'(m5.sd.w2);
      plo[3] <= 66'(py[33:0]) * 66'(m5.sd.w2);
      phi[3] <= 65'(py[66:34]) * 65'(m5.sd.w2);
    end
  end

  // stage 7: numerators, divider entry
  dv_t  dv  [Q_W+1];
  logic dvv [Q_W+1];
  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (ce) begin
      dvv[0] <= v6;
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      dv[0].i1  <= m6.sd.i1;
      dv[0].i2  <= m6.sd.i2;
      dv[0].p1x <= m6.sd.p1x;
      dv[0].p1y <= m6.sd.p1y;
      dv[0].p2x <= m6.sd.p2x;
      dv[0].p2y <= m6.sd.p2y;
      dv[0].neg <= {m6.mneg ^ m6.sd.ny, m6.mneg ^ m6.sd.nx,
                    m6.mneg ^ m6.sd.ny, m6.mneg ^ m6.sd.nx};
      dv[0].st  <= m6.st;
      dv[0].den <= den6;
      for (int l = 0; l < LANES; l++) begin
        dv[0].num[l] <= NUM_W'(plo[l]) + {phi[l][NUM_W-35:0], 34'd0};
        dv[0].rem[l] <= '0;
        dv[0].q[l]   <= '0;
      end
    end
  end

  // restoring divider, one quotient bit per stage; quotient never exceeds the length error
  for (genvar k = 0; k < Q_W; k++) begin : g_div
    logic [LANES-1:0][PROD_W:0] r2;
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          r2[l] = {2'b00, dv[k].num[l][NUM_W-1 -: NUM_W-Q_W], dv[k].num[l][Q_W-1]};
        end else begin
          r2[l] = {dv[k].rem[l], dv[k].num[l][Q_W-1-k]};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[k+1] <= 1'b0;
      end else if (ce) begin
        dvv[k+1] <= dvv[k];
      end
    end
    always_ff @(posedge clk) begin
      if (ce) begin
        dv[k+1].i1  <= dv[k].i1;
        dv[k+1].i2  <= dv[k].i2;
        dv[k+1].p1x <= dv[k].p1x;
        dv[k+1].p1y <= dv[k].p1y;
        dv[k+1].p2x <= dv[k].p2x;
        dv[k+1].p2y <= dv[k].p2y;
        dv[k+1].neg <= dv[k].neg;
        dv[k+1].st  <= dv[k].st;
        dv[k+1].den <= dv[k].den;
        dv[k+1].num <= dv[k].num;
        for (int l = 0; l < LANES; l++) begin
          if (r2[l] >= {1'b0, dv[k].den}) begin
            dv[k+1].rem[l] <= PROD_W'(r2[l] - {1'b0, dv[k].den});
            dv[k+1].q[l]   <= {dv[k].q[l][Q_W-2:0], 1'b1};
          end else begin
            dv[k+1].rem[l] <= PROD_W'(r2[l]);
            dv[k+1].q[l]   <= {dv[k].q[l][Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // output stage: apply corrections and saturate, or pass the positions through on a skip
  dv_t dl;
  logic signed [LANES-1:0][35:0] corr;
  logic [LANES-1:0][31:0] res;
  always_comb begin
    dl = dv[Q_W];
    for (int l = 0; l < LANES; l++) begin
      corr[l] = dl.neg[l] ? -$signed({2'b00, dl.q[l]}) : $signed({2'b00, dl.q[l]});
    end
    res[0] = sat32(36'(dl.p1x) - corr[0]);
    res[1] = sat32(36'(dl.p1y) - corr[1]);
    res[2] = sat32(36'(dl.p2x) + corr[2]);
    res[3] = sat32(36'(dl.p2y) + corr[3]);
    if (dl.st != ST_CORRECTED) begin
      res[0] = dl.p1x;
      res[1] = dl.p1y;
      res[2] = dl.p2x;
      res[3] = dl.p2y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ce) begin
      m_tvalid <= dvv[Q_W];
    end
  end
  always_ff @(posedge clk) begin
    if (ce) begin
      m_tdata <= {res[3], res[2], res[1], res[0], dl.i2, dl.i1};
      m_tuser <= dl.st;
    end
  end

endmodule

### hw/rtl/dcp_checker.sv
// Port-level checker for the distance constraint projection, bound to the top level
`include "distance_constraint_projection_defines.svh"

module dcp_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [dcp_pkg::OUT_W-1:0] m_tdata,
  input logic [1:0]                m_tuser
);
  import dcp_pkg::*;

  `DCP_ASSERT(a_hold_out, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output changed while stalled")
  `DCP_ASSERT(a_stall_in, m_tvalid && !m_tready |-> !s_tready, "input taken while pipeline stalled")
  `DCP_ASSERT(a_ready_out, m_tready |-> s_tready, "input refused while output drains")
  `DCP_ASSERT(a_status, m_tvalid |-> m_tuser != 2'd3, "status code out of range")
  `DCP_ASSERT_RST(a_reset, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind distance_constraint_projection dcp_checker u_dcp_checker (.*);

### tb/distance_constraint_projection_checker.sv
// Checker for the distance constraint projection: predicts each result and compares it
module distance_constraint_projection_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  input  logic                      s_tready,
  input  logic [dcp_pkg::IN_W-1:0]  s_tdata,
  input  logic                      m_tvalid,
  input  logic                      m_tready,
  input  logic [dcp_pkg::OUT_W-1:0] m_tdata,
  input  logic [1:0]                m_tuser,
  output int                        fail_count,
  output int                        pending_count
);
  import dcp_pkg::*;

  typedef struct packed {
    logic [15:0] i1;
    logic [15:0] i2;
    logic [31:0] n1x;
    logic [31:0] n1y;
    logic [31:0] n2x;
    logic [31:0] n2y;
    logic [1:0]  st;
  } projection_t;

  projection_t projected_q[$];

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // signed step of one component: weight * |m| * |c| / den, truncated in magnitude
  function automatic longint shift_amount(logic [127:0] w, logic [127:0] mabs, logic mneg,
                                          longint comp, logic [127:0] den);
    logic [127:0] cabs;
    logic [127:0] q;
    cabs = (comp < 0) ? 128'(-comp) : 128'(comp);
    q = (w * mabs * cabs) / den;
    return (mneg != (comp < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic projection_t project_constraint(logic [IN_W-1:0] d);
    projection_t r;
    longint p1x, p1y, p2x, p2y, dx, dy, n1x, n1y, n2x, n2y, m;
    logic [127:0] w1, w2, ax, ay, sq, span, cand, mabs, den;
    logic mneg;
    p1x = longint'($signed(d[94:63]));
    p1y = longint'($signed(d[126:95]));
    p2x = longint'($signed(d[158:127]));
    p2y = longint'($signed(d[190:159]));
    w1 = 128'(d[222:191]);
    w2 = 128'(d[254:223]);
    n1x = p1x; n1y = p1y; n2x = p2x; n2y = p2y;
    r.i1 = d[15:0];
    r.i2 = d[31:16];
    r.st = ST_CORRECTED;
    if (w1 == 0 && w2 == 0) begin
      r.st = ST_MASS_ZERO;
    end else begin
      dx = p1x - p2x;
      dy = p1y - p2y;
      ax = (dx < 0) ? 128'(-dx) : 128'(dx);
      ay = (dy < 0) ? 128'(-dy) : 128'(dy);
      sq = ax * ax + ay * ay;
      span = 0;
      for (int b = 33; b >= 0; b--) begin
        cand = span | (128'd1 << b);
        if (cand * cand <= sq) span = cand;
      end
      if (span == 0) begin
        r.st = ST_COINCIDENT;
      end else begin
        m = longint'(span[63:0]) - longint'(d[62:32]);
        mneg = m < 0;
        mabs = mneg ? 128'(-m) : 128'(m);
        den = (w1 + w2) * span;
        n1x = p1x - shift_amount(w1, mabs, mneg, dx, den);
        n1y = p1y - shift_amount(w1, mabs, mneg, dy, den);
        n2x = p2x + shift_amount(w2, mabs, mneg, dx, den);
        n2y = p2y + shift_amount(w2, mabs, mneg, dy, den);
      end
    end
    r.n1x = clamp32(n1x);
    r.n1y = clamp32(n1y);
    r.n2x = clamp32(n2x);
    r.n2y = clamp32(n2y);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;
  assign pending_count = projected_q.size();

  always @(posedge clk) begin
    projection_t e;
    if (!rst) begin
      if (s_tvalid && s_tready) projected_q.push_back(project_constraint(s_tdata));
      if (m_tvalid && m_tready) begin
        if (projected_q.size() == 0) begin
          $error("unexpected result transfer: %h status %0d", m_tdata, m_tuser);
          fail_count++;
        end else begin
          e = projected_q.pop_front();
          check_field("out_first_index", 32'(e.i1), 32'(m_tdata[15:0]));
          check_field("out_second_index", 32'(e.i2), 32'(m_tdata[31:16]));
          check_field("new_first_x", e.n1x, m_tdata[63:32]);
          check_field("new_first_y", e.n1y, m_tdata[95:64]);
          check_field("new_second_x", e.n2x, m_tdata[127:96]);
          check_field("new_second_y", e.n2y, m_tdata[159:128]);
          check_field("status", 32'(e.st), 32'(m_tuser));
        end
      end
    end
  end
endmodule

### tb/tb_distance_constraint_projection.sv
// Testbench top for the distance constraint projection: stimulus, stalls and verdict
module tb_distance_constraint_projection;
  import dcp_pkg::*;

  localparam int RANDOM_ITEMS = 730;
  localparam int QUIET_AFTER  = 620;

  logic                clk = 0;
  logic                rst = 1;
  logic                s_tvalid = 0;
  logic                s_tready;
  logic [IN_W-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1;
  logic [OUT_W-1:0]    m_tdata;
  logic [1:0]          m_tuser;
  logic                s_fire = 0;
  logic                quiet = 0;
  int                  fail_count;
  int                  pending_count;
  int                  stall_left = 0;

  always #4 clk = ~clk;

  distance_constraint_projection u_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  distance_constraint_projection_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .fail_count, .pending_count
  );

  always @(posedge clk) s_fire <= s_tvalid && s_tready;

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_tready = 0;
    end else if (!quiet && $urandom_range(0, 19) == 0) begin
      stall_left = $urandom_range(0, 14);
      m_tready = 0;
    end else begin
      m_tready = 1;
    end
  end

  function automatic logic [IN_W-1:0] pack_constraint(
      logic [15:0] i1, logic [15:0] i2, logic [30:0] rest,
      logic [31:0] p1x, logic [31:0] p1y, logic [31:0] p2x, logic [31:0] p2y,
      logic [31:0] w1, logic [31:0] w2);
    return {1'b0, w2, w1, p2y, p2x, p1y, p1x, rest, i2, i1};
  endfunction

  // call at a falling edge; returns at the falling edge after the transfer
  task automatic send_constraint(logic [IN_W-1:0] d);
    int gap;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 15);
      s_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata  = d;
    do @(negedge clk); while (!s_fire);
  endtask

  function automatic logic [31:0] near(logic [31:0] base);
    return base + 32'($signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000);
  endfunction

  task automatic send_random();
    logic [31:0] p1x, p1y, p2x, p2y, w1, w2;
    logic [30:0] rest;
    int mode;
    mode = $urandom_range(0, 9);
    p1x = $urandom; p1y = $urandom; p2x = $urandom; p2y = $urandom;
    w1 = $urandom; w2 = $urandom;
    rest = 31'($urandom);
    if (mode >= 1 && mode <= 6) begin
      p2x = near(p1x);
      p2y = near(p1y);
      rest = 31'($urandom_range(0, 32'h40_0000));
      w1 = $urandom_range(0, 3) == 0 ? 32'd0 : 32'($urandom_range(1, 32'h4_0000));
      w2 = $urandom_range(0, 3) == 0 ? 32'd0 : 32'($urandom_range(1, 32'h4_0000));
    end else if (mode == 7) begin
      w1 = 0;
      w2 = 0;
    end else if (mode == 8) begin
      p2x = p1x;
      p2y = p1y;
    end else if (mode == 9) begin
      p1x = {p1x[31], {31{~p1x[31]}}};
      p2x = ~p1x;
      w1 = 32'hffff_ffff - 32'($urandom_range(0, 255));
    end
    send_constraint(pack_constraint(16'($urandom), 16'($urandom), rest, p1x, p1y, p2x, p2y,
                                    w1, w2));
  endtask

  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send_constraint(pack_constraint(16'h0000, 16'hffff, 31'd0, 32'h0, 32'h0, 32'h0001_0000,
                                    32'h0, 32'h1_0000, 32'h1_0000));
    send_constraint(pack_constraint(16'h1234, 16'h1234, 31'h0002_0000, 32'h0, 32'h0,
                                    32'h0001_0000, 32'h0001_0000, 32'h1_0000, 32'h0));
    send_constraint(pack_constraint(16'hffff, 16'h0000, 31'h7fff_ffff, 32'h7fff_ffff,
                                    32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                    32'hffff_ffff, 32'hffff_ffff));
    send_constraint(pack_constraint(16'h0001, 16'h0002, 31'd0, 32'h7fff_ffff, 32'h7fff_ffff,
                                    32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h1));
    send_constraint(pack_constraint(16'h0003, 16'h0004, 31'h10_0000, 32'h8000_0000,
                                    32'h0, 32'h7fff_ffff, 32'h0, 32'h0, 32'hffff_ffff));
    send_constraint(pack_constraint(16'h0005, 16'h0006, 31'h1234, 32'h1111_0000,
                                    32'h2222_0000, 32'h3333_0000, 32'h4444_0000, 32'h0, 32'h0));
    send_constraint(pack_constraint(16'h0007, 16'h0008, 31'h7fff_ffff, 32'h8000_0000,
                                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0));
    send_constraint(pack_constraint(16'h0009, 16'h000a, 31'h5_0000, 32'h1234_5678,
                                    32'hfedc_ba98, 32'h1234_5678, 32'hfedc_ba98,
                                    32'h1_0000, 32'h2_0000));
    send_constraint(pack_constraint(16'h000b, 16'h000c, 31'h7fff_ffff, 32'h0, 32'h0, 32'h0,
                                    32'h0, 32'hffff_ffff, 32'h0));
    send_constraint(pack_constraint(16'h000d, 16'h000e, 31'h3_0000, 32'h0, 32'h0, 32'h0,
                                    32'h1, 32'h8000, 32'h8000));
    send_constraint(pack_constraint(16'h000f, 16'h0010, 31'd0, 32'h7fff_ffff, 32'h0,
                                    32'h7fff_fffe, 32'h0, 32'hffff_ffff, 32'hffff_ffff));
    send_constraint(pack_constraint(16'h8000, 16'h7fff, 31'h2_0000, 32'hffff_0000,
                                    32'hffff_0000, 32'h0001_0000, 32'h0001_0000,
                                    32'h1_0000, 32'h3_0000));
    send_constraint(pack_constraint(16'haaaa, 16'h5555, 31'h5555_5555, 32'haaaa_aaaa,
                                    32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa,
                                    32'haaaa_aaaa, 32'h5555_5555));
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == QUIET_AFTER) quiet = 1;
      send_random();
    end
    s_tvalid = 0;
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
